// ----- rtl/bqc_pkg.sv -----
package bqc_pkg;

   localparam int SAMPLE_W     = 24;
   localparam int COEF_W       = 32;
   localparam int STATE_W      = 40;
   localparam int COEF_FRAC    = COEF_W - 3;
   localparam int OPCODE_W     = 2;
   localparam int SECTION_W    = 3;
   localparam int SLOT_W       = 3;
   localparam int SEC_IDX_W    = 4;
   localparam int CSR_W        = 4;
   localparam int NUM_COEF     = 5;
   localparam int NUM_ST_WORDS = 2;

   localparam logic [OPCODE_W-1:0] OP_FILTER   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_COEF_WR  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_STATE_WR = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_STATE_RD = 2'd3;

   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

   localparam logic ST_WORD_FIRST  = 1'b0;
   localparam logic ST_WORD_SECOND = 1'b1;

   // accumulator targets
   localparam logic [1:0] ACC_Y  = 2'd0;
   localparam logic [1:0] ACC_S0 = 2'd1;
   localparam logic [1:0] ACC_S1 = 2'd2;

   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_SAMPLE,
      RSP_STATE
   } rsp_kind_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]         opcode;
      logic [SECTION_W-1:0]        section_index;
      logic [SLOT_W-1:0]           slot_index;
      logic signed [SAMPLE_W-1:0]  sample_in;
      logic signed [COEF_W-1:0]    coef_value;
      logic signed [STATE_W-1:0]   state_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  sample_out;
      logic signed [STATE_W-1:0]   state_out;
   } rsp_type;

   typedef struct packed {
      logic                  mul_go;
      logic                  mul_use_y;
      logic [1:0]            mul_acc;
      logic                  mul_sub;
      logic [SEC_IDX_W-1:0]  sec;
      logic [SLOT_W-1:0]     slot;
      logic                  word;
      logic                  coef_wr;
      logic                  st_wr;
      logic                  st_rd;
      logic                  commit_y;
      logic                  commit_st;
      logic                  x_from_y;
      logic                  rsp_load;
      rsp_kind_type          rsp_kind;
   } cmd_type;

endpackage

// ----- rtl/biquad_cascade_iir_filter_core.sv -----
// filter beat: runs the N active sections in turn, N = active sections capped at MAX_SECTIONS;
// each section uses the single shared multiplier and waits for its output before its
// feedback products. a new request is taken only once the previous response is pushed.
// coefficient and state beats, and filter beats with no active section, skip the
// sections and go straight to the output. reset is synchronous: it clears control, the
// section count and the store valid bits, so both stores read zero right away.
module biquad_cascade_iir_filter_core #(
   parameter int MAX_SECTIONS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bqc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bqc_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bqc_pkg::CSR_W-1:0]     csr_data
);

   logic             req_take;
   bqc_pkg::cmd_type cmd;

   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   bqc_ctrl #(.MAX_SECTIONS(MAX_SECTIONS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_data.opcode),
      .req_section (req_data.section_index),
      .req_slot    (req_data.slot_index),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd)
   );

   bqc_datapath #(.MAX_SECTIONS(MAX_SECTIONS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_take    (req_take),
      .sample_in   (req_data.sample_in),
      .coef_value  (req_data.coef_value),
      .state_value (req_data.state_value),
      .cmd         (cmd),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- rtl/bqc_ram.sv -----
module bqc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 40,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bqc_datapath.sv -----
module bqc_datapath #(
   parameter int MAX_SECTIONS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_take,
   input  logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_in,
   input  logic signed [bqc_pkg::COEF_W-1:0]     coef_value,
   input  logic signed [bqc_pkg::STATE_W-1:0]    state_value,
   input  bqc_pkg::cmd_type                      cmd,
   output bqc_pkg::rsp_type                      rsp_data
);

   localparam int STATE_W = bqc_pkg::STATE_W;
   localparam int COEF_W  = bqc_pkg::COEF_W;
   localparam int SMP_W   = bqc_pkg::SAMPLE_W;
   localparam int C_DEPTH = MAX_SECTIONS * bqc_pkg::NUM_COEF;
   localparam int S_DEPTH = MAX_SECTIONS * bqc_pkg::NUM_ST_WORDS;
   localparam int C_AW    = $clog2(C_DEPTH);
   localparam int S_AW    = $clog2(S_DEPTH);
   localparam int CAF_W   = bqc_pkg::SEC_IDX_W + 3;
   localparam int V_LO_W  = STATE_W / 2;
   localparam int V_HI_W  = STATE_W - V_LO_W;
   localparam int LO_W    = COEF_W + V_LO_W + 1;
   localparam int HI_W    = COEF_W + V_HI_W;
   localparam int PROD_W  = HI_W + V_LO_W;
   localparam int RND_W   = PROD_W - bqc_pkg::COEF_FRAC;
   localparam int ACC_W   = RND_W + 1;
   localparam int SUM_W   = ACC_W + 1;

   localparam logic signed [PROD_W-1:0] RND_HALF =
      {{(PROD_W - bqc_pkg::COEF_FRAC){1'b0}}, 1'b1, {(bqc_pkg::COEF_FRAC - 1){1'b0}}};
   localparam logic signed [PROD_W-1:0] RND_HALF_M1 = RND_HALF - PROD_W'(1);
   localparam logic signed [STATE_W-1:0] ST_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] ST_MIN  = {1'b1, {(STATE_W-1){1'b0}}};
   localparam logic signed [SMP_W-1:0]   SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
   localparam logic signed [SMP_W-1:0]   SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0] acc;
      logic       sub;
   } mctl_type;

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
      logic signed [STATE_W-1:0] r;
      if (v > SUM_W'(ST_MAX)) begin
         r = ST_MAX;
      end else if (v < SUM_W'(ST_MIN)) begin
         r = ST_MIN;
      end else begin
         r = v[STATE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SMP_W-1:0] sat_sample(input logic signed [STATE_W-1:0] v);
      logic signed [SMP_W-1:0] r;
      if (v > STATE_W'(SMP_MAX)) begin
         r = SMP_MAX;
      end else if (v < STATE_W'(SMP_MIN)) begin
         r = SMP_MIN;
      end else begin
         r = v[SMP_W-1:0];
      end
      return r;
   endfunction

   // request payload
   logic signed [COEF_W-1:0]  coef_val_ff;
   logic signed [STATE_W-1:0] st_val_ff;
   logic signed [STATE_W-1:0] x_ff, x_in;
   logic signed [STATE_W-1:0] y_ff;

   // addressing
   logic [CAF_W-1:0] c_addr_full;
   logic [C_AW-1:0]  c_addr;
   logic [bqc_pkg::SEC_IDX_W:0] s_addr_full;
   logic [S_AW-1:0]  s_addr;

   // stores and valid bits
   logic             c_vld_ff [C_DEPTH];
   logic             s_vld_ff [S_DEPTH];
   logic             c_ok_ff, s_ok_ff;
   logic [COEF_W-1:0]  coef_q;
   logic [STATE_W-1:0] st_ram_q;
   logic signed [COEF_W-1:0]  c_val;
   logic signed [STATE_W-1:0] st_q;
   logic                      st_we;
   logic [STATE_W-1:0]        st_wdata;

   // multiplier pipeline
   logic                      go0_ff, go1_ff, go2_ff, go3_ff;
   mctl_type                  ctl0_ff, ctl1_ff, ctl2_ff, ctl3_ff;
   logic signed [STATE_W-1:0] opnd_ff;
   logic signed [V_LO_W:0]    v_lo;
   logic signed [LO_W-1:0]    lo_in, lo1_ff;
   logic signed [COEF_W-1:0]  c1_ff;
   logic signed [V_HI_W-1:0]  vhi1_ff;
   logic signed [HI_W-1:0]    hi_p;
   logic signed [PROD_W-1:0]  prod_in, prod2_ff;
   logic signed [PROD_W-1:0]  rnd_sum;
   logic signed [RND_W-1:0]   rnd_in, rnd3_ff;
   logic signed [ACC_W-1:0]   rnd_ext;
   logic signed [ACC_W-1:0]   accy_ff, accs0_ff, accs1_ff;

   // commit
   logic signed [SUM_W-1:0]   y_sum, s0_sum, s1_sum;
   logic signed [STATE_W-1:0] commit_val;
   bqc_pkg::rsp_type          rsp_ff, rsp_in;

   assign c_addr_full = CAF_W'(cmd.sec) * CAF_W'(bqc_pkg::NUM_COEF) + CAF_W'(cmd.slot);
   assign c_addr      = c_addr_full[C_AW-1:0];
   assign s_addr_full = {cmd.sec, cmd.word};
   assign s_addr      = s_addr_full[S_AW-1:0];

   bqc_ram #(.WIDTH(COEF_W), .DEPTH(C_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.coef_wr),
      .wr_addr (c_addr),
      .wr_data (coef_val_ff),
      .rd_en   (cmd.mul_go),
      .rd_addr (c_addr),
      .rd_data (coef_q)
   );

   bqc_ram #(.WIDTH(STATE_W), .DEPTH(S_DEPTH)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (s_addr),
      .wr_data (st_wdata),
      .rd_en   (cmd.st_rd),
      .rd_addr (s_addr),
      .rd_data (st_ram_q)
   );

   // entries never written read as zero
   assign c_val = c_ok_ff ? $signed(coef_q) : '0;
   assign st_q  = s_ok_ff ? $signed(st_ram_q) : '0;

   assign v_lo    = $signed({1'b0, opnd_ff[V_LO_W-1:0]});
   assign lo_in   = LO_W'(c_val) * LO_W'(v_lo);
   assign hi_p    = HI_W'(c1_ff) * HI_W'(vhi1_ff);
   assign prod_in = $signed({hi_p, {V_LO_W{1'b0}}}) + PROD_W'(lo1_ff);

   // round half away from zero
   assign rnd_sum = prod2_ff + (prod2_ff[PROD_W-1] ? RND_HALF_M1 : RND_HALF);
   assign rnd_in  = $signed(rnd_sum[PROD_W-1:bqc_pkg::COEF_FRAC]);
   assign rnd_ext = ACC_W'(rnd3_ff);

   assign y_sum  = SUM_W'(accy_ff) + SUM_W'(st_q);
   assign s0_sum = SUM_W'(accs0_ff) + SUM_W'(st_q);
   assign s1_sum = SUM_W'(accs1_ff);
   assign commit_val = (cmd.word == bqc_pkg::ST_WORD_SECOND) ? sat_state(s1_sum)
                                                             : sat_state(s0_sum);

   assign st_we    = cmd.st_wr | cmd.commit_st;
   assign st_wdata = cmd.commit_st ? commit_val : st_val_ff;

   always_comb begin
      x_in = x_ff;
      if (req_take) begin
         x_in = STATE_W'(sample_in);
      end else if (cmd.x_from_y) begin
         x_in = y_ff;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         case (cmd.rsp_kind)
            bqc_pkg::RSP_SAMPLE: begin
               rsp_in.sample_out = sat_sample(x_ff);
               rsp_in.state_out  = '0;
            end
            bqc_pkg::RSP_STATE: begin
               rsp_in.sample_out = '0;
               rsp_in.state_out  = st_q;
            end
            default: begin
               rsp_in.sample_out = '0;
               rsp_in.state_out  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < C_DEPTH; i++) begin
            c_vld_ff[i] <= 1'b0;
         end
         for (int i = 0; i < S_DEPTH; i++) begin
            s_vld_ff[i] <= 1'b0;
         end
         go0_ff <= 1'b0;
         go1_ff <= 1'b0;
         go2_ff <= 1'b0;
         go3_ff <= 1'b0;
      end else begin
         if (cmd.coef_wr) begin
            c_vld_ff[c_addr] <= 1'b1;
         end
         if (st_we) begin
            s_vld_ff[s_addr] <= 1'b1;
         end
         go0_ff <= cmd.mul_go;
         go1_ff <= go0_ff;
         go2_ff <= go1_ff;
         go3_ff <= go2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         coef_val_ff <= coef_value;
         st_val_ff   <= state_value;
      end
      x_ff   <= x_in;
      rsp_ff <= rsp_in;
      if (cmd.commit_y) begin
         y_ff <= sat_state(y_sum);
      end
      if (cmd.mul_go) begin
         c_ok_ff  <= c_vld_ff[c_addr];
         opnd_ff  <= cmd.mul_use_y ? y_ff : x_ff;
         ctl0_ff  <= '{acc: cmd.mul_acc, sub: cmd.mul_sub};
      end
      if (cmd.st_rd) begin
         s_ok_ff <= s_vld_ff[s_addr];
      end
      // split product: low half of the operand first, then the high half
      c1_ff    <= c_val;
      vhi1_ff  <= $signed(opnd_ff[STATE_W-1:V_LO_W]);
      lo1_ff   <= lo_in;
      ctl1_ff  <= ctl0_ff;
      prod2_ff <= prod_in;
      ctl2_ff  <= ctl1_ff;
      rnd3_ff  <= rnd_in;
      ctl3_ff  <= ctl2_ff;
      if (go3_ff) begin
         case (ctl3_ff.acc)
            bqc_pkg::ACC_Y: begin
               accy_ff <= ctl3_ff.sub ? accy_ff - rnd_ext : rnd_ext;
            end
            bqc_pkg::ACC_S0: begin
               accs0_ff <= ctl3_ff.sub ? accs0_ff - rnd_ext : rnd_ext;
            end
            bqc_pkg::ACC_S1: begin
               accs1_ff <= ctl3_ff.sub ? accs1_ff - rnd_ext : rnd_ext;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/bqc_ctrl.sv -----
module bqc_ctrl #(
   parameter int MAX_SECTIONS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bqc_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [bqc_pkg::SECTION_W-1:0]     req_section,
   input  logic [bqc_pkg::SLOT_W-1:0]        req_slot,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              csr_valid,
   input  logic [bqc_pkg::CSR_W-1:0]         csr_data,
   output bqc_pkg::cmd_type                  cmd
);

   localparam int SEC_W = bqc_pkg::SEC_IDX_W;

   // per-section schedule of the shared multiplier
   localparam logic [3:0] STEP_B0    = 4'd0;
   localparam logic [3:0] STEP_B1    = 4'd1;
   localparam logic [3:0] STEP_B2    = 4'd2;
   localparam logic [3:0] STEP_RD_S0 = 4'd4;
   localparam logic [3:0] STEP_Y     = 4'd5;
   localparam logic [3:0] STEP_A1    = 4'd6;
   localparam logic [3:0] STEP_A2    = 4'd7;
   localparam logic [3:0] STEP_RD_S1 = 4'd10;
   localparam logic [3:0] STEP_S0    = 4'd11;
   localparam logic [3:0] STEP_S1    = 4'd12;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILT,
      ST_OUT,
      ST_PUSH
   } state_type;

   state_type                  state_ff, state_in;
   logic [3:0]                 step_ff, step_in;
   logic [SEC_W-1:0]           sec_ff, sec_in;
   logic [bqc_pkg::CSR_W-1:0]  active_ff, active_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bqc_pkg::rsp_kind_type      kind_ff, kind_in;
   bqc_pkg::cmd_type           cmd_ff, cmd_in;
   logic [4:0]                 n_eff;
   logic                       sec_ok, last_sec;

   assign n_eff = (5'(active_ff) > 5'(MAX_SECTIONS)) ? 5'(MAX_SECTIONS) : 5'(active_ff);
   assign sec_ok   = 5'(req_section) < 5'(MAX_SECTIONS);
   assign last_sec = (5'(sec_ff) + 5'd1) == n_eff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sec_in       = sec_ff;
      kind_in      = kind_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = '0;
      if (csr_valid) begin
         active_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in.sec  = SEC_W'(req_section);
               cmd_in.slot = req_slot;
               cmd_in.word = req_slot[0];
               state_in    = ST_OUT;
               kind_in     = bqc_pkg::RSP_ZERO;
               case (req_opcode)
                  bqc_pkg::OP_FILTER: begin
                     kind_in = bqc_pkg::RSP_SAMPLE;
                     sec_in  = '0;
                     step_in = STEP_B0;
                     if (n_eff != 5'd0) begin
                        state_in = ST_FILT;
                     end
                  end
                  bqc_pkg::OP_COEF_WR: begin
                     cmd_in.coef_wr = sec_ok && (req_slot < 3'(bqc_pkg::NUM_COEF));
                  end
                  bqc_pkg::OP_STATE_WR: begin
                     cmd_in.st_wr = sec_ok && (req_slot < 3'(bqc_pkg::NUM_ST_WORDS));
                  end
                  bqc_pkg::OP_STATE_RD: begin
                     if (sec_ok && (req_slot < 3'(bqc_pkg::NUM_ST_WORDS))) begin
                        cmd_in.st_rd = 1'b1;
                        kind_in      = bqc_pkg::RSP_STATE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILT: begin
            cmd_in.sec = sec_ff;
            step_in    = step_ff + 4'd1;
            case (step_ff)
               STEP_B0: begin
                  cmd_in.mul_go  = 1'b1;
                  cmd_in.slot    = bqc_pkg::SLOT_B0;
                  cmd_in.mul_acc = bqc_pkg::ACC_Y;
               end
               STEP_B1: begin
                  cmd_in.mul_go  = 1'b1;
                  cmd_in.slot    = bqc_pkg::SLOT_B1;
                  cmd_in.mul_acc = bqc_pkg::ACC_S0;
               end
               STEP_B2: begin
                  cmd_in.mul_go  = 1'b1;
                  cmd_in.slot    = bqc_pkg::SLOT_B2;
                  cmd_in.mul_acc = bqc_pkg::ACC_S1;
               end
               STEP_RD_S0: begin
                  cmd_in.st_rd = 1'b1;
                  cmd_in.word  = bqc_pkg::ST_WORD_FIRST;
               end
               STEP_Y: begin
                  cmd_in.commit_y = 1'b1;
               end
               STEP_A1: begin
                  cmd_in.mul_go    = 1'b1;
                  cmd_in.mul_use_y = 1'b1;
                  cmd_in.mul_sub   = 1'b1;
                  cmd_in.slot      = bqc_pkg::SLOT_A1;
                  cmd_in.mul_acc   = bqc_pkg::ACC_S0;
               end
               STEP_A2: begin
                  cmd_in.mul_go    = 1'b1;
                  cmd_in.mul_use_y = 1'b1;
                  cmd_in.mul_sub   = 1'b1;
                  cmd_in.slot      = bqc_pkg::SLOT_A2;
                  cmd_in.mul_acc   = bqc_pkg::ACC_S1;
               end
               STEP_RD_S1: begin
                  cmd_in.st_rd = 1'b1;
                  cmd_in.word  = bqc_pkg::ST_WORD_SECOND;
               end
               STEP_S0: begin
                  cmd_in.commit_st = 1'b1;
                  cmd_in.word      = bqc_pkg::ST_WORD_FIRST;
               end
               STEP_S1: begin
                  cmd_in.commit_st = 1'b1;
                  cmd_in.word      = bqc_pkg::ST_WORD_SECOND;
                  cmd_in.x_from_y  = 1'b1;
                  step_in          = STEP_B0;
                  if (last_sec) begin
                     state_in = ST_OUT;
                  end else begin
                     sec_in = sec_ff + SEC_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_OUT: begin
            // output register free by the next edge
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd_in.rsp_load = 1'b1;
               cmd_in.rsp_kind = kind_ff;
               state_in        = ST_PUSH;
            end
         end
         ST_PUSH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_B0;
         sec_ff       <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= bqc_pkg::RSP_ZERO;
         cmd_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sec_ff       <= sec_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         cmd_ff       <= cmd_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ----- dv/tb_biquad_cascade_iir_filter_core.sv -----
`timescale 1ns / 100ps

module tb_biquad_cascade_iir_filter_core;

   localparam int SECTIONS     = 8;
   localparam int DRAIN_TICKS  = 13 * SECTIONS + 16;

   localparam int SAMPLE_W     = bqc_pkg::SAMPLE_W;
   localparam int COEF_W       = bqc_pkg::COEF_W;
   localparam int STATE_W      = bqc_pkg::STATE_W;
   localparam int COEF_FRAC    = bqc_pkg::COEF_FRAC;
   localparam int OPCODE_W     = bqc_pkg::OPCODE_W;
   localparam int SECTION_W    = bqc_pkg::SECTION_W;
   localparam int SLOT_W       = bqc_pkg::SLOT_W;
   localparam int CSR_W        = bqc_pkg::CSR_W;
   localparam int NUM_COEF     = bqc_pkg::NUM_COEF;
   localparam int NUM_ST_WORDS = bqc_pkg::NUM_ST_WORDS;

   localparam logic [SLOT_W-1:0] SLOT_COEF_UNUSED  = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_STATE_UNUSED = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_LAST         = 3'd7;
   localparam logic [SLOT_W-1:0] SLOT_ST_FIRST     = SLOT_W'(bqc_pkg::ST_WORD_FIRST);
   localparam logic [SLOT_W-1:0] SLOT_ST_SECOND    = SLOT_W'(bqc_pkg::ST_WORD_SECOND);

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0]   COEF_ONE   = 32'sd1 <<< COEF_FRAC;
   localparam logic signed [STATE_W-1:0]  STATE_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0]  STATE_MIN  = {1'b1, {(STATE_W-1){1'b0}}};
   localparam logic [127:0]               PRODUCT_CAP = 128'd1 << 60;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   bqc_pkg::req_type    req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   bqc_pkg::rsp_type    rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_data  = '0;

   // shadow of the block's stores and section count
   longint              coef_mem [SECTIONS*NUM_COEF];
   longint              state_mem [SECTIONS*NUM_ST_WORDS];
   logic [CSR_W-1:0]    active_count = '0;

   bqc_pkg::rsp_type    outputs_due[$];
   int                  mismatch_count = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_idle_pct = 0;
   int                  plan_pos = 0;
   logic [CSR_W-1:0]    section_plan [12] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd8,
                                              4'd9, 4'd5, 4'd2, 4'd8, 4'd0, 4'd6};

   biquad_cascade_iir_filter_core #(
      .MAX_SECTIONS(SECTIONS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   function automatic longint clamp_to(input longint v, input int w);
      longint top;
      top = (longint'(1) <<< (w - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
   endfunction

   // coefficient times value, rounded half away from zero at the value's scale
   function automatic longint round_product(input longint c, input longint v);
      logic [127:0] mag;
      logic         neg;
      neg = (c < 0) != (v < 0);
      mag = 128'(c < 0 ? -c : c) * 128'(v < 0 ? -v : v);
      mag = (mag + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
      if (mag > PRODUCT_CAP) mag = PRODUCT_CAP;
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic bqc_pkg::rsp_type apply_request(input bqc_pkg::req_type item);
      bqc_pkg::rsp_type res;
      longint  x;
      longint  y;
      int      n;
      int      k;
      int      base;
      res = '0;
      case (item.opcode)
         bqc_pkg::OP_FILTER: begin
            n = (active_count > SECTIONS) ? SECTIONS : int'(active_count);
            x = item.sample_in;
            for (k = 0; k < n; k++) begin
               base = k * NUM_COEF;
               y = clamp_to(round_product(coef_mem[base + bqc_pkg::SLOT_B0], x)
                            + state_mem[2*k], STATE_W);
               state_mem[2*k] = clamp_to(round_product(coef_mem[base + bqc_pkg::SLOT_B1], x)
                                         - round_product(coef_mem[base + bqc_pkg::SLOT_A1], y)
                                         + state_mem[2*k+1], STATE_W);
               state_mem[2*k+1] = clamp_to(round_product(coef_mem[base + bqc_pkg::SLOT_B2], x)
                                           - round_product(coef_mem[base + bqc_pkg::SLOT_A2],
                                                           y),
                                           STATE_W);
               x = y;
            end
            y = clamp_to(x, SAMPLE_W);
            res.sample_out = y[SAMPLE_W-1:0];
         end
         bqc_pkg::OP_COEF_WR: begin
            if (item.section_index < SECTIONS && item.slot_index < NUM_COEF)
               coef_mem[item.section_index*NUM_COEF + item.slot_index] = item.coef_value;
         end
         bqc_pkg::OP_STATE_WR: begin
            if (item.section_index < SECTIONS && item.slot_index < NUM_ST_WORDS)
               state_mem[item.section_index*NUM_ST_WORDS + item.slot_index] =
                  item.state_value;
         end
         default: begin
            if (item.section_index < SECTIONS && item.slot_index < NUM_ST_WORDS) begin
               y = state_mem[item.section_index*NUM_ST_WORDS + item.slot_index];
               res.state_out = y[STATE_W-1:0];
            end
         end
      endcase
      return res;
   endfunction

   function automatic bqc_pkg::req_type random_request();
      bqc_pkg::req_type r;
      logic [63:0]      wide;
      wide = {$urandom, $urandom};
      r.opcode        = wide[1:0];
      r.section_index = wide[4:2];
      r.slot_index    = wide[7:5];
      r.sample_in     = wide[31:8];
      r.coef_value    = wide[63:32];
      wide = {$urandom, $urandom};
      r.state_value   = wide[STATE_W-1:0];
      return r;
   endfunction

   function automatic bqc_pkg::req_type make_request(input logic [OPCODE_W-1:0] op,
                                                     input logic [SECTION_W-1:0] section,
                                                     input logic [SLOT_W-1:0] slot);
      bqc_pkg::req_type r;
      r = random_request();
      r.opcode        = op;
      r.section_index = section;
      r.slot_index    = slot;
      return r;
   endfunction

   // mostly legal slots and random sections, with full-range and extreme values mixed in
   function automatic bqc_pkg::req_type traffic_request();
      bqc_pkg::req_type r;
      int               pick;
      r = random_request();
      pick = $urandom_range(99);
      if (pick < 55) r.opcode = bqc_pkg::OP_FILTER;
      else if (pick < 75) r.opcode = bqc_pkg::OP_COEF_WR;
      else if (pick < 85) r.opcode = bqc_pkg::OP_STATE_WR;
      else r.opcode = bqc_pkg::OP_STATE_RD;
      if ($urandom_range(99) < 85) begin
         if (r.opcode == bqc_pkg::OP_COEF_WR)
            r.slot_index = SLOT_W'($urandom_range(NUM_COEF - 1));
         else
            r.slot_index = SLOT_W'($urandom_range(NUM_ST_WORDS - 1));
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
         r.coef_value = r.coef_value >>> 3;
      end else if (pick < 85) begin
      end else begin
         case ($urandom_range(3))
            0: r.coef_value = COEF_MAX;
            1: r.coef_value = COEF_MIN;
            2: r.coef_value = COEF_ONE;
            default: r.coef_value = '0;
         endcase
      end
      pick = $urandom_range(99);
      if (pick < 50) r.state_value = r.state_value >>> 15;
      else if (pick < 55) r.state_value = STATE_MAX;
      else if (pick < 60) r.state_value = STATE_MIN;
      pick = $urandom_range(99);
      if (pick < 5) r.sample_in = SAMPLE_MAX;
      else if (pick < 10) r.sample_in = SAMPLE_MIN;
      return r;
   endfunction

   task automatic send_request(input bqc_pkg::req_type item);
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      outputs_due.push_back(apply_request(item));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_section_count(input logic [CSR_W-1:0] count);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      active_count = count;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : check_outputs
      bqc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outputs_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected beat, sample_out %0d state_out %0d", $time,
                        rsp_data.sample_out, rsp_data.state_out);
         end else begin
            want = outputs_due.pop_front();
            if (rsp_data.sample_out !== want.sample_out)
               report_mismatch("sample_out", want.sample_out, rsp_data.sample_out);
            if (rsp_data.state_out !== want.state_out)
               report_mismatch("state_out", want.state_out, rsp_data.state_out);
         end
      end
   end

   // no section active after reset: samples come straight through
   task automatic test_passthrough();
      bqc_pkg::req_type r;
      r = make_request(bqc_pkg::OP_FILTER, '0, '0);
      r.sample_in = SAMPLE_MAX;
      send_request(r);
      r = make_request(bqc_pkg::OP_FILTER, '0, '0);
      r.sample_in = SAMPLE_MIN;
      send_request(r);
      r = make_request(bqc_pkg::OP_FILTER, '0, '0);
      r.sample_in = '0;
      send_request(r);
   endtask

   task automatic test_store_access();
      bqc_pkg::req_type          r;
      logic signed [COEF_W-1:0]  coef_set [NUM_COEF];
      int                        s;
      coef_set = '{COEF_MAX, COEF_MIN, COEF_ONE, -(COEF_ONE >>> 1), COEF_ONE >>> 2};
      for (s = 0; s < NUM_COEF; s++) begin
         r = make_request(bqc_pkg::OP_COEF_WR, '0, SLOT_W'(s));
         r.coef_value = coef_set[s];
         send_request(r);
      end
      // unused slots must leave the stores alone
      send_request(make_request(bqc_pkg::OP_COEF_WR, '0, SLOT_COEF_UNUSED));
      r = make_request(bqc_pkg::OP_STATE_WR, '0, SLOT_ST_FIRST);
      r.state_value = STATE_MAX;
      send_request(r);
      r = make_request(bqc_pkg::OP_STATE_WR, '0, SLOT_ST_SECOND);
      r.state_value = STATE_MIN;
      send_request(r);
      send_request(make_request(bqc_pkg::OP_STATE_WR, '0, SLOT_STATE_UNUSED));
      send_request(make_request(bqc_pkg::OP_STATE_RD, '0, SLOT_ST_SECOND));
      send_request(make_request(bqc_pkg::OP_STATE_RD, '0, SLOT_LAST));
      send_request(make_request(bqc_pkg::OP_STATE_RD, 3'd7, SLOT_ST_FIRST));
   endtask

   task automatic test_saturation();
      bqc_pkg::req_type r;
      write_section_count(4'd1);
      r = make_request(bqc_pkg::OP_FILTER, '0, '0);
      r.sample_in = SAMPLE_MIN;
      send_request(r);
      r = make_request(bqc_pkg::OP_FILTER, '0, '0);
      r.sample_in = SAMPLE_MAX;
      send_request(r);
      send_request(make_request(bqc_pkg::OP_STATE_RD, '0, SLOT_ST_FIRST));
      send_request(make_request(bqc_pkg::OP_STATE_RD, '0, SLOT_ST_SECOND));
   endtask

   // a count above the section limit runs every section
   task automatic test_section_limit();
      bqc_pkg::req_type r;
      write_section_count(4'd15);
      r = make_request(bqc_pkg::OP_FILTER, '0, '0);
      r.sample_in = SAMPLE_MAX >>> 1;
      send_request(r);
      send_request(make_request(bqc_pkg::OP_STATE_RD, 3'd7, SLOT_ST_SECOND));
   endtask

   task automatic test_inactive_sections_hold();
      bqc_pkg::req_type r;
      write_section_count(4'd2);
      r = make_request(bqc_pkg::OP_STATE_WR, 3'd5, SLOT_ST_FIRST);
      r.state_value = STATE_MAX >>> 3;
      send_request(r);
      send_request(make_request(bqc_pkg::OP_FILTER, '0, '0));
      send_request(make_request(bqc_pkg::OP_STATE_RD, 3'd5, SLOT_ST_FIRST));
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      bqc_pkg::req_type r;
      int               block;
      int               counted;
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
      for (block = 0; block < 4; block++) begin
         write_section_count(section_plan[plan_pos]);
         plan_pos++;
         counted = 0;
         while (counted < 100) begin
            r = traffic_request();
            send_request(r);
            // writes to unused slots do nothing and are not counted
            if (!((r.opcode == bqc_pkg::OP_COEF_WR && r.slot_index >= NUM_COEF) ||
                  (r.opcode == bqc_pkg::OP_STATE_WR && r.slot_index >= NUM_ST_WORDS)))
               counted++;
         end
      end
   endtask

   initial begin
      foreach (coef_mem[i]) coef_mem[i] = 0;
      foreach (state_mem[i]) state_mem[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 29;
      receiver_idle_pct = 79;
      test_passthrough();
      test_store_access();
      test_saturation();
      test_section_limit();
      test_inactive_sections_hold();

      test_random_traffic(29, 79);
      test_random_traffic(79, 29);
      test_random_traffic(0, 0);

      wait_drained();
      repeat (DRAIN_TICKS) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
